/* rtl/rtc_pkg.sv */
// Shared types, sizes and command codes for the range table match counter.
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;

  localparam int MAX_INTERVALS = 256;
  localparam int VAL_W         = 48;
  localparam int HIT_W         = 32;
  localparam int CMD_W         = 2;
  localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [HIT_W-1:0] hit_cnt_t;

  localparam cnt_t     CNT_FULL = cnt_t'(MAX_INTERVALS);
  localparam hit_cnt_t HIT_MAX  = '1;

  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
    logic             wr;
    logic             drop;
    cnt_t             used;
    val_t             key;
    val_t             hi;
    logic             hit;
  } beat_t;

endpackage
`default_nettype wire

/* rtl/rtc_cell.sv */
// One table cell: holds one interval, matches a passing query and forwards the beat.
`timescale 1ns / 1ps
`default_nettype none
module rtc_cell
  import rtc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire idx_t  cell_idx,
  input  wire beat_t beat_in,
  output beat_t      beat_out
);

  val_t  lo_r;
  val_t  hi_r;
  beat_t beat_r;
  beat_t beat_nxt;
  logic  capture;
  logic  live;
  logic  match;

  always_comb begin
    capture = beat_in.valid && beat_in.wr && (beat_in.used[IDX_W-1:0] == cell_idx);
    live    = cnt_t'(cell_idx) < beat_in.used;
    match   = beat_in.valid && (beat_in.cmd == CMD_QUERY) && live &&
              (lo_r <= beat_in.key) && (beat_in.key <= hi_r);
    beat_nxt     = beat_in;
    beat_nxt.hit = beat_in.hit | match;
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      lo_r <= beat_in.key;
      hi_r <= beat_in.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.cmd  <= beat_nxt.cmd;
    beat_r.wr   <= beat_nxt.wr;
    beat_r.drop <= beat_nxt.drop;
    beat_r.used <= beat_nxt.used;
    beat_r.key  <= beat_nxt.key;
    beat_r.hi   <= beat_nxt.hi;
    beat_r.hit  <= beat_nxt.hit;
  end

  assign beat_out = beat_r;

endmodule
`default_nettype wire

/* rtl/rtc_tail.sv */
// Chain tail: saturating hit counter and registered result beat.
`timescale 1ns / 1ps
`default_nettype none
module rtc_tail
  import rtc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire beat_t beat_in,
  output logic       out_valid,
  output logic       out_hit,
  output hit_cnt_t   out_hit_total,
  output logic       out_load_dropped
);

  hit_cnt_t hits_r;
  hit_cnt_t hits_nxt;
  logic     valid_r;
  logic     hit_r;
  logic     drop_r;
  logic     q_hit;

  always_comb begin
    q_hit    = beat_in.valid && (beat_in.cmd == CMD_QUERY) && beat_in.hit;
    hits_nxt = hits_r;
    if (beat_in.valid && (beat_in.cmd == CMD_CLEAR)) begin
      hits_nxt = '0;
    end else if (q_hit && (hits_r != HIT_MAX)) begin
      hits_nxt = hits_r + hit_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      hits_r  <= hits_nxt;
      valid_r <= beat_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= q_hit;
    drop_r <= beat_in.drop;
  end

  assign out_valid        = valid_r;
  assign out_hit          = hit_r;
  assign out_hit_total    = hits_r;
  assign out_load_dropped = drop_r;

endmodule
`default_nettype wire

/* rtl/range_table_match_counter.sv */
// Top level: command entry, chain of interval cells and result tail.
`timescale 1ns / 1ps
`default_nettype none
// Range table match counter. A command is taken on any cycle with start high and busy low;
// busy is high in reset and goes low once reset is released, so from then one command a
// cycle is taken. Each command walks a chain of MAX_INTERVALS cells, one cell a cycle, and its
// result beat, registered in every cell and then in the tail, shows on the out_ ports with
// out_valid high, in command order. Results cannot be held off: sample them in the strobe
// cycle.
module range_table_match_counter
  import rtc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CMD_W-1:0] in_cmd,
  input  wire val_t             in_interval_low,
  input  wire val_t             in_interval_high,
  input  wire val_t             in_query_value,
  output logic                  out_valid,
  output logic                  out_hit,
  output hit_cnt_t              out_hit_total,
  output logic                  out_load_dropped
);

  logic  busy_r;
  cnt_t  entries_used_r;
  cnt_t  entries_used_nxt;
  logic  accept;
  logic  is_load;
  logic  load_ok;
  beat_t head_beat;
  beat_t chain [MAX_INTERVALS+1];

  assign accept  = start && !busy_r;
  assign is_load = in_cmd == CMD_LOAD;
  assign load_ok = is_load && (entries_used_r != CNT_FULL);

  always_comb begin
    entries_used_nxt = entries_used_r;
    if (accept && (in_cmd == CMD_CLEAR)) begin
      entries_used_nxt = '0;
    end else if (accept && load_ok) begin
      entries_used_nxt = entries_used_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b1;
      entries_used_r <= '0;
    end else begin
      busy_r         <= 1'b0;
      entries_used_r <= entries_used_nxt;
    end
  end

  always_comb begin
    head_beat.valid = accept;
    head_beat.cmd   = in_cmd;
    head_beat.wr    = load_ok;
    head_beat.drop  = is_load && !load_ok;
    head_beat.used  = entries_used_r;
    head_beat.key   = is_load ? in_interval_low : in_query_value;
    head_beat.hi    = in_interval_high;
    head_beat.hit   = 1'b0;
  end

  assign chain[0] = head_beat;

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    rtc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (idx_t'(k)),
      .beat_in  (chain[k]),
      .beat_out (chain[k+1])
    );
  end

  rtc_tail u_tail (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat_in          (chain[MAX_INTERVALS]),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_total    (out_hit_total),
    .out_load_dropped (out_load_dropped)
  );

  assign busy = busy_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entries_used_r <= CNT_FULL)
    else $error("entry count past table size");

  a_hit_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_load_dropped)
    else $error("hit and dropped load on one beat");

  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_total != '0)
    else $error("hit reported with zero count");

  a_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule
`default_nettype wire
